FILE: hw/rtl/mdsc_pkg.sv
// shared types and codes for the duty sweep tracker
package mdsc_pkg;

    localparam int DutyWidth  = 16;
    localparam int PowerPort  = 24;
    localparam int ResWidth   = 5;
    localparam int StageWidth = 2;
    localparam int TaskWidth  = 2;

    // tracker stages
    localparam logic [StageWidth-1:0] StageSetup      = 2'd0;
    localparam logic [StageWidth-1:0] StageSetDuty    = 2'd1;
    localparam logic [StageWidth-1:0] StageCheckPower = 2'd2;
    localparam logic [StageWidth-1:0] StageCheckMpp   = 2'd3;

    // next task codes
    localparam logic [TaskWidth-1:0] TaskSend = 2'd0;
    localparam logic [TaskWidth-1:0] TaskMppt = 2'd1;
    localparam logic [TaskWidth-1:0] TaskMeas = 2'd2;

    localparam logic [ResWidth-1:0] ResReset = 5'd10;
    localparam logic [ResWidth-1:0] ResMax   = 5'd16;

    typedef struct packed {
        logic                  duty_write;
        logic [DutyWidth-1:0]  duty_value;
        logic [TaskWidth-1:0]  next_task;
        logic                  sweep_done;
        logic                  optimum_write;
        logic [PowerPort-1:0]  optimum_power;
    } result_t;

endpackage

FILE: hw/rtl/mdsc_step.sv
// next-state and result logic for one tracker run
module mdsc_step #(
    parameter int BEST_WIDTH = 24
) (
    input  logic [mdsc_pkg::StageWidth-1:0] stage,
    input  logic [mdsc_pkg::DutyWidth-1:0]  sweep_duty,
    input  logic [mdsc_pkg::DutyWidth-1:0]  best_duty,
    input  logic [BEST_WIDTH-1:0]           best_power,
    input  logic [mdsc_pkg::ResWidth-1:0]   resolution,
    input  logic                            permitted,
    input  logic [mdsc_pkg::PowerPort-1:0]  power,
    output logic [mdsc_pkg::StageWidth-1:0] stage_next,
    output logic [mdsc_pkg::DutyWidth-1:0]  sweep_duty_next,
    output logic [mdsc_pkg::DutyWidth-1:0]  best_duty_next,
    output logic [BEST_WIDTH-1:0]           best_power_next,
    output mdsc_pkg::result_t               result
);

    logic [mdsc_pkg::ResWidth-1:0]  res_clamped;
    logic [mdsc_pkg::DutyWidth:0]   max_duty;
    logic [mdsc_pkg::DutyWidth:0]   duty_inc;
    logic                           power_better;
    logic [mdsc_pkg::DutyWidth-1:0] best_duty_upd;

    assign res_clamped  = (resolution > mdsc_pkg::ResMax) ? mdsc_pkg::ResMax : resolution;
    assign max_duty     = (17'd1 << res_clamped) - 17'd1;
    assign duty_inc     = {1'b0, sweep_duty} + 17'd1;
    assign power_better = power[BEST_WIDTH-1:0] > best_power;
    assign best_duty_upd = power_better ? sweep_duty : best_duty;

    always_comb begin
        stage_next      = stage;
        sweep_duty_next = sweep_duty;
        best_duty_next  = best_duty;
        best_power_next = best_power;
        result          = '0;
        result.next_task = mdsc_pkg::TaskSend;
        unique case (stage)
            mdsc_pkg::StageSetup: begin
                if (!permitted) begin
                    result.sweep_done = 1'b1;
                end else begin
                    sweep_duty_next  = 16'd1;
                    best_duty_next   = '0;
                    best_power_next  = '0;
                    stage_next       = mdsc_pkg::StageSetDuty;
                    result.next_task = mdsc_pkg::TaskMppt;
                end
            end
            mdsc_pkg::StageSetDuty: begin
                result.duty_write = 1'b1;
                result.duty_value = sweep_duty;
                result.next_task  = mdsc_pkg::TaskMeas;
                stage_next        = mdsc_pkg::StageCheckPower;
            end
            mdsc_pkg::StageCheckPower: begin
                if (power_better) begin
                    best_power_next = power[BEST_WIDTH-1:0];
                end
                best_duty_next  = best_duty_upd;
                sweep_duty_next = duty_inc[mdsc_pkg::DutyWidth-1:0];
                if (duty_inc >= max_duty) begin
                    result.duty_write = 1'b1;
                    result.duty_value = best_duty_upd;
                    result.next_task  = mdsc_pkg::TaskMeas;
                    stage_next        = mdsc_pkg::StageCheckMpp;
                end else begin
                    result.next_task  = mdsc_pkg::TaskMppt;
                    stage_next        = mdsc_pkg::StageSetDuty;
                end
            end
            default: begin
                result.optimum_write = 1'b1;
                result.optimum_power = power;
                result.sweep_done    = 1'b1;
                stage_next           = mdsc_pkg::StageSetup;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mppt_duty_sweep_controller.sv
// top level of the maximum power point duty sweep tracker
// Sweep tracker for the maximum power point of a PWM converter. Each input word is one
// run of the tracker: a permission flag and the power measured since the last duty was
// applied. Each input word yields exactly one result word. When permitted, the tracker
// walks the duty from 1 upward, alternating a duty write with a power check, keeps the
// duty of strictly greatest power, writes that best duty once the sweep reaches
// 2^duty_resolution_bits - 1 (resolution above 16 acts as 16), and reports the next
// measured power as the optimum. A word passes an input register and then a result
// register, from which its result is offered; one word is accepted every cycle as long
// as the result side keeps taking words, since the combinational step logic between the
// two registers is the only stage touching the tracker state. POWER_WIDTH (8..48) sets
// how many low bits of power_sample take part; at 24 and above all do. The user must
// write duty_resolution_bits through cfg_wen/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
module mppt_duty_sweep_controller #(
    parameter int POWER_WIDTH = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wen,
    input  logic [mdsc_pkg::ResWidth-1:0]  cfg_wdata,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_permitted,
    input  logic [mdsc_pkg::PowerPort-1:0] s_power_sample,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_duty_write,
    output logic [mdsc_pkg::DutyWidth-1:0] m_duty_value,
    output logic [mdsc_pkg::TaskWidth-1:0] m_next_task,
    output logic                           m_sweep_done,
    output logic                           m_optimum_write,
    output logic [mdsc_pkg::PowerPort-1:0] m_optimum_power
);

    // effective power width, never wider than the port
    localparam int BestWidth = (POWER_WIDTH < mdsc_pkg::PowerPort) ?
                               POWER_WIDTH : mdsc_pkg::PowerPort;
    localparam logic [mdsc_pkg::PowerPort-1:0] PowerMask =
        mdsc_pkg::PowerPort'((25'd1 << BestWidth) - 25'd1);

    // configuration register
    logic [mdsc_pkg::ResWidth-1:0] res_reg;

    // input register
    logic                           in_valid_reg;
    logic                           in_permitted_reg;
    logic [mdsc_pkg::PowerPort-1:0] in_power_reg;

    // tracker state
    logic [mdsc_pkg::StageWidth-1:0] stage_reg;
    logic [mdsc_pkg::DutyWidth-1:0]  sweep_duty_reg;
    logic [mdsc_pkg::DutyWidth-1:0]  best_duty_reg;
    logic [BestWidth-1:0]            best_power_reg;

    logic [mdsc_pkg::StageWidth-1:0] stage_next;
    logic [mdsc_pkg::DutyWidth-1:0]  sweep_duty_next;
    logic [mdsc_pkg::DutyWidth-1:0]  best_duty_next;
    logic [BestWidth-1:0]            best_power_next;

    // result register
    logic              out_valid_reg;
    mdsc_pkg::result_t out_result_reg;
    mdsc_pkg::result_t step_result;

    logic advance;
    logic accept;

    // a word moves into the result register when that slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // the input register takes a new word when empty or moving on this cycle
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= mdsc_pkg::ResReset;
        end else if (cfg_wen) begin
            res_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload, masked to the effective power width on entry
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_permitted_reg <= s_permitted;
            in_power_reg     <= s_power_sample & PowerMask;
        end
    end

    mdsc_step #(
        .BEST_WIDTH (BestWidth)
    ) u_step (
        .stage           (stage_reg),
        .sweep_duty      (sweep_duty_reg),
        .best_duty       (best_duty_reg),
        .best_power      (best_power_reg),
        .resolution      (res_reg),
        .permitted       (in_permitted_reg),
        .power           (in_power_reg),
        .stage_next      (stage_next),
        .sweep_duty_next (sweep_duty_next),
        .best_duty_next  (best_duty_next),
        .best_power_next (best_power_next),
        .result          (step_result)
    );

    // tracker state moves only when a word passes the step logic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= mdsc_pkg::StageSetup;
            sweep_duty_reg <= '0;
            best_duty_reg  <= '0;
            best_power_reg <= '0;
        end else if (advance) begin
            stage_reg      <= stage_next;
            sweep_duty_reg <= sweep_duty_next;
            best_duty_reg  <= best_duty_next;
            best_power_reg <= best_power_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_duty_write    = out_result_reg.duty_write;
    assign m_duty_value    = out_result_reg.duty_value;
    assign m_next_task     = out_result_reg.next_task;
    assign m_sweep_done    = out_result_reg.sweep_done;
    assign m_optimum_write = out_result_reg.optimum_write;
    assign m_optimum_power = out_result_reg.optimum_power;

    // during the sweep the duty is never zero and always ahead of the best duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == mdsc_pkg::StageSetDuty || stage_reg == mdsc_pkg::StageCheckPower)
        |-> (sweep_duty_reg != '0 && best_duty_reg < sweep_duty_reg))
        else $error("sweep duty out of order with best duty");

    // the optimum check always ends the run and reports the optimum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage_reg == mdsc_pkg::StageCheckMpp)
        |=> (stage_reg == mdsc_pkg::StageSetup && m_valid && m_optimum_write && m_sweep_done))
        else $error("optimum check did not finish the run");

    // a held result word is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result word overwritten while stalled");

endmodule
